@@ rtl/core/ffa_pkg.sv @@
package ffa_pkg;

  localparam int MAX_EXTENTS_DEF     = 32;
  localparam int PAGE_INDEX_BITS_DEF = 20;

  localparam int BASE_W  = PAGE_INDEX_BITS_DEF;
  localparam int COUNT_W = PAGE_INDEX_BITS_DEF + 1;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_INSERT = 3'd1;
  localparam logic [2:0] ACT_TRIM   = 3'd2;
  localparam logic [2:0] ACT_REMOVE = 3'd3;
  localparam logic [2:0] ACT_BOTH   = 3'd4;
  localparam logic [2:0] ACT_FRONT  = 3'd5;
  localparam logic [2:0] ACT_BACK   = 3'd6;

  typedef struct packed {
    logic       en;
    logic [2:0] act;
  } ffa_ctl_t;

endpackage

@@ rtl/core/ffa_cell.sv @@
module ffa_cell #(
  parameter int SW = 21,
  parameter int LW = 22
) (
  input  logic              clk,
  input  ffa_pkg::ffa_ctl_t ctl,
  input  logic [SW-1:0]     base,
  input  logic [LW-1:0]     cnt,
  input  logic              valid,
  input  logic              le_prev,
  input  logic              le_next,
  input  logic              fit_seen_in,
  input  logic [SW-1:0]     left_start,
  input  logic [LW-1:0]     left_len,
  input  logic [SW-1:0]     right_start,
  input  logic [LW-1:0]     right_len,
  output logic [SW-1:0]     start_q,
  output logic [LW-1:0]     len_q,
  output logic              le,
  output logic              fit_seen_out,
  output logic              hit,
  output logic              front_hit,
  output logic              back_hit
);
  import ffa_pkg::*;

  logic [SW-1:0] start_r, start_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          fit, is_pos, is_prev;
  logic [LW+1:0] sum1, sum2;
  logic [LW:0]   end_pg, new_end;

  // le runs down the chain: set only while every cell so far starts at or below base
  assign le      = le_prev && valid && (start_r <= base);
  assign fit     = valid && (len_r >= cnt);
  assign hit     = fit && !fit_seen_in;
  assign fit_seen_out = fit_seen_in | fit;
  assign is_pos  = le_prev && !le;
  assign is_prev = le && !le_next;
  assign end_pg  = (LW+1)'(start_r) + (LW+1)'(len_r);
  assign new_end = (LW+1)'(base) + (LW+1)'(cnt);
  assign front_hit = is_prev && (end_pg == (LW+1)'(base));
  assign back_hit  = is_pos && valid && (new_end == (LW+1)'(start_r));
  assign start_q = start_r;
  assign len_q   = len_r;

  // saturating merged lengths; all-ones stands above any request count
  assign sum1 = (LW+2)'(len_r) + (LW+2)'(cnt);
  assign sum2 = sum1 + (LW+2)'(right_len);

  always_comb begin
    start_nxt = start_r;
    len_nxt   = len_r;
    case (ctl.act)
      ACT_INSERT: begin
        if (is_pos) begin
          start_nxt = base;
          len_nxt   = cnt;
        end else if (!le_prev) begin
          start_nxt = left_start;
          len_nxt   = left_len;
        end
      end
      ACT_TRIM: begin
        if (hit) begin
          start_nxt = start_r + SW'(cnt);
          len_nxt   = len_r - cnt;
        end
      end
      ACT_REMOVE: begin
        if (fit_seen_out) begin
          start_nxt = right_start;
          len_nxt   = right_len;
        end
      end
      ACT_BOTH: begin
        if (is_prev) begin
          len_nxt = (sum2 > (LW+2)'({LW{1'b1}})) ? {LW{1'b1}} : sum2[LW-1:0];
        end else if (!le) begin
          start_nxt = right_start;
          len_nxt   = right_len;
        end
      end
      ACT_FRONT: begin
        if (is_prev) begin
          len_nxt = (sum1 > (LW+2)'({LW{1'b1}})) ? {LW{1'b1}} : sum1[LW-1:0];
        end
      end
      ACT_BACK: begin
        if (is_pos) begin
          start_nxt = base;
          len_nxt   = (sum1 > (LW+2)'({LW{1'b1}})) ? {LW{1'b1}} : sum1[LW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      start_r <= start_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

@@ rtl/core/first_fit_page_allocator.sv @@
// First-fit page allocator over a chain of extent cells.
// The accepted word is registered, then a parallel compare/shift step across the
// cell chain updates the table and the result registers; that step waits while an
// unread result sees out_tready low. A new request is accepted only after that step.
// Reset (rst_n low, synchronous) empties the table and zeroes the free count.
module first_fit_page_allocator #(
  parameter int MAX_EXTENTS = ffa_pkg::MAX_EXTENTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // base_page[19:0], page_count[40:20]
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // alloc_page[19:0], free_total[40:20]
  output logic [1:0]  out_tuser   // status[1:0]
);
  import ffa_pkg::*;

  localparam int PB = PAGE_INDEX_BITS_DEF;
  localparam int SW = PB + 1;
  localparam int LW = (PB + 2 > 22) ? PB + 2 : 22;
  localparam int IW = $clog2(MAX_EXTENTS + 1);
  localparam int N  = MAX_EXTENTS;

  logic              busy_r, busy_nxt;
  logic [1:0]        op_r;
  logic [PB-1:0]     base_r;
  logic [COUNT_W-1:0] cnt_r;
  logic [IW-1:0]     used_r, used_nxt;
  logic [SW-1:0]     free_r, free_nxt;
  logic              ov_r;
  logic [1:0]        st_r, st_nxt;
  logic [PB-1:0]     ap_r, ap_nxt;
  logic              exec;
  ffa_ctl_t          ctl;

  logic [SW-1:0] base_x;
  logic [LW-1:0] cnt_raw, cnt_x, room;

  logic [SW-1:0] c_start [N];
  logic [LW-1:0] c_len   [N];
  logic [N-1:0]  c_le, c_seen, c_hit, c_front, c_back, c_valid;
  logic          any_fit, front, back, full;
  logic [SW-1:0] hit_start;
  logic [LW:0]   free_sum;

  assign in_tready = !busy_r;
  assign exec      = busy_r && (!ov_r || out_tready);

  always_comb begin
    base_x  = SW'(base_r);
    cnt_raw = LW'(cnt_r);
    room    = (LW'(1) << PB) - LW'(base_r);
    cnt_x   = (op_r != OP_ALLOC && cnt_raw > room) ? room : cnt_raw;
  end

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      assign c_valid[g] = (IW'(g) < used_r);
      ffa_cell #(.SW(SW), .LW(LW)) u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .base        (base_x),
        .cnt         (cnt_x),
        .valid       (c_valid[g]),
        .le_prev     ((g == 0) ? 1'b1 : c_le[(g == 0) ? 0 : g-1]),
        .le_next     ((g == N-1) ? 1'b0 : c_le[(g == N-1) ? g : g+1]),
        .fit_seen_in ((g == 0) ? 1'b0 : c_seen[(g == 0) ? 0 : g-1]),
        .left_start  (c_start[(g == 0) ? 0 : g-1]),
        .left_len    (c_len[(g == 0) ? 0 : g-1]),
        .right_start (c_start[(g == N-1) ? g : g+1]),
        .right_len   (c_len[(g == N-1) ? g : g+1]),
        .start_q     (c_start[g]),
        .len_q       (c_len[g]),
        .le          (c_le[g]),
        .fit_seen_out(c_seen[g]),
        .hit         (c_hit[g]),
        .front_hit   (c_front[g]),
        .back_hit    (c_back[g])
      );
    end
  endgenerate

  always_comb begin
    hit_start = '0;
    for (int i = 0; i < N; i++) begin
      if (c_hit[i]) hit_start = hit_start | c_start[i];
    end
  end

  function automatic logic [LW-1:0] hit_len(input logic [N-1:0] h);
    logic [LW-1:0] r;
    r = '0;
    for (int i = 0; i < N; i++) begin
      if (h[i]) r = r | c_len[i];
    end
    return r;
  endfunction

  assign any_fit  = c_seen[N-1];
  assign front    = |c_front;
  assign back     = |c_back;
  assign full     = (used_r == IW'(N));
  assign free_sum = (LW+1)'(free_r) + (LW+1)'(cnt_x);

  always_comb begin
    ctl.en   = exec;
    ctl.act  = ACT_NONE;
    st_nxt   = ST_OK;
    ap_nxt   = '0;
    used_nxt = used_r;
    free_nxt = free_r;
    if (op_r inside {OP_ADD, OP_ALLOC, OP_FREE}) begin
      if (cnt_raw == '0) begin
        st_nxt = ST_ZERO;
      end else if (op_r == OP_ALLOC) begin
        if (cnt_raw > LW'(free_r) || !any_fit) begin
          st_nxt = ST_NOFIT;
        end else begin
          ap_nxt   = hit_start[PB-1:0];
          free_nxt = free_r - SW'(cnt_raw);
          if (|(c_hit & c_seen) && cnt_raw == hit_len(c_hit)) begin
            ctl.act  = ACT_REMOVE;
            used_nxt = used_r - IW'(1);
          end else begin
            ctl.act = ACT_TRIM;
          end
        end
      end else begin
        if (op_r == OP_FREE && front && back) begin
          ctl.act  = ACT_BOTH;
          used_nxt = used_r - IW'(1);
        end else if (op_r == OP_FREE && front) begin
          ctl.act = ACT_FRONT;
        end else if (op_r == OP_FREE && back) begin
          ctl.act = ACT_BACK;
        end else if (full) begin
          st_nxt = ST_FULL;
        end else begin
          ctl.act  = ACT_INSERT;
          used_nxt = used_r + IW'(1);
        end
        if (st_nxt == ST_OK) begin
          free_nxt = (free_sum > (LW+1)'({SW{1'b1}})) ? {SW{1'b1}} : free_sum[SW-1:0];
        end
      end
    end
  end

  assign busy_nxt = (in_tvalid && in_tready) ? 1'b1 : (exec ? 1'b0 : busy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
      used_r <= '0;
      free_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      if (exec) begin
        ov_r   <= 1'b1;
        used_r <= used_nxt;
        free_r <= free_nxt;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r   <= in_tuser;
      base_r <= PB'(in_tdata[BASE_W-1:0]);
      cnt_r  <= in_tdata[BASE_W +: COUNT_W];
    end
    if (exec) begin
      st_r <= st_nxt;
      ap_r <= ap_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = st_r;
  assign out_tdata  = {7'd0, COUNT_W'(free_r), BASE_W'(ap_r)};

  a_used_max: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= IW'(N)) else $error("extent count past table size");
  a_err_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    exec && st_nxt != ST_OK |=> $stable(used_r) && $stable(free_r))
    else $error("failed request changed state");
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(c_hit) && $onehot0(c_front) && $onehot0(c_back))
    else $error("more than one cell selected");
  a_exec_busy: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> !busy_r) else $error("request executed twice");

endmodule
